### src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HUE_W    = 9;
  localparam int PCT_W    = 7;
  localparam int CH_W     = 8;
  localparam int SV_W     = 14;   // s*v and v*(100-s) stay at or below 10000
  localparam int FRAC_W   = 6;    // ramp position within a sector, 0..60
  localparam int HM_W     = 7;    // hue folded onto 0..119
  localparam int NUM_W    = 20;   // channel numerator in units of 1/600000
  localparam int DIV_W    = 18;   // numerator*17/64, at most 159375
  localparam int RECIP_W  = 15;
  localparam int RECIP_SH = 24;

  localparam logic [HUE_W-1:0] HUE_TURN    = HUE_W'(360);
  localparam logic [PCT_W-1:0] PCT_FULL    = PCT_W'(100);
  localparam int               SECTOR_DEG  = 60;
  localparam int               SCALE_MUL   = 17;     // 255/600000 = 17/(64*625)
  localparam int               SCALE_SHIFT = 6;
  localparam int               SCALE_DIV   = 625;
  // floor(2^24 / 625), estimate is never high and at most one low
  localparam logic [RECIP_W-1:0] RECIP_625 = RECIP_W'(26843);

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // advance strobes for the three register stages inside a unit
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
  } stage_adv_t;

endpackage

### src/hsv2rgb_front.sv
`timescale 1ns / 1ps

module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic                   clk,
  input  stage_adv_t             adv,
  input  logic [HUE_W-1:0]       hue,
  input  logic [PCT_W-1:0]       saturation,
  input  logic [PCT_W-1:0]       brightness,
  output sector_t                sector,
  output logic [NUM_W-1:0]       chroma,
  output logic [NUM_W-1:0]       second,
  output logic [NUM_W-1:0]       offset
);

  // stage 1: clamp, sector and ramp position
  logic [HUE_W-1:0]  h_c;
  logic [PCT_W-1:0]  s_c;
  logic [PCT_W-1:0]  v_c;
  logic [HM_W-1:0]   hm;
  sector_t           sec_next;
  logic [FRAC_W-1:0] frac_next;

  sector_t           sec1;
  logic [FRAC_W-1:0] frac1;
  logic [PCT_W-1:0]  s1;
  logic [PCT_W-1:0]  v1;

  always_comb begin
    h_c = (hue >= HUE_TURN) ? '0 : hue;
    s_c = (saturation > PCT_FULL) ? PCT_FULL : saturation;
    v_c = (brightness > PCT_FULL) ? PCT_FULL : brightness;

    if (h_c < HUE_W'(60))       sec_next = SEC_RY;
    else if (h_c < HUE_W'(120)) sec_next = SEC_YG;
    else if (h_c < HUE_W'(180)) sec_next = SEC_GC;
    else if (h_c < HUE_W'(240)) sec_next = SEC_CB;
    else if (h_c < HUE_W'(300)) sec_next = SEC_BM;
    else                        sec_next = SEC_MR;

    if (h_c >= HUE_W'(240))      hm = HM_W'(h_c - HUE_W'(240));
    else if (h_c >= HUE_W'(120)) hm = HM_W'(h_c - HUE_W'(120));
    else                         hm = HM_W'(h_c);

    // triangle wave: rises over even sectors, falls over odd ones
    if (hm >= HM_W'(SECTOR_DEG)) frac_next = FRAC_W'(HM_W'(120) - hm);
    else                         frac_next = FRAC_W'(hm);
  end

  always_ff @(posedge clk) begin
    if (adv.st1) begin
      sec1  <= sec_next;
      frac1 <= frac_next;
      s1    <= s_c;
      v1    <= v_c;
    end
  end

  // stage 2: percent products
  sector_t           sec2;
  logic [FRAC_W-1:0] frac2;
  logic [SV_W-1:0]   sv2;
  logic [SV_W-1:0]   vm2;

  always_ff @(posedge clk) begin
    if (adv.st2) begin
      sec2  <= sec1;
      frac2 <= frac1;
      sv2   <= SV_W'(s1) * SV_W'(v1);
      vm2   <= SV_W'(v1) * SV_W'(PCT_FULL - s1);
    end
  end

  // stage 3: components over the common denominator 600000
  always_ff @(posedge clk) begin
    if (adv.st3) begin
      sector <= sec2;
      chroma <= NUM_W'(sv2) * NUM_W'(SECTOR_DEG);
      second <= NUM_W'(frac2) * NUM_W'(sv2);
      offset <= NUM_W'(vm2) * NUM_W'(SECTOR_DEG);
    end
  end

endmodule

### src/hsv2rgb_scale.sv
`timescale 1ns / 1ps

module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  stage_adv_t        adv,
  input  logic [NUM_W-1:0]  num,
  output logic [CH_W-1:0]   level
);

  localparam int PRE_W  = NUM_W + 5;
  localparam int PROD_W = DIV_W + RECIP_W;

  // stage 1: times 17, drop 6 bits (floor composes exactly)
  logic [PRE_W-1:0] pre;
  logic [DIV_W-1:0] a1;

  assign pre = PRE_W'(num) * PRE_W'(SCALE_MUL);

  always_ff @(posedge clk) begin
    if (adv.st1) begin
      a1 <= pre[DIV_W+SCALE_SHIFT-1:SCALE_SHIFT];
    end
  end

  // stage 2: reciprocal estimate of a / 625
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  a2;
  logic [CH_W-1:0]   est2;

  assign prod = PROD_W'(a1) * PROD_W'(RECIP_625);

  always_ff @(posedge clk) begin
    if (adv.st2) begin
      a2   <= a1;
      est2 <= prod[RECIP_SH+CH_W-1:RECIP_SH];
    end
  end

  // stage 3: one-step correction
  logic [DIV_W-1:0] rem;

  assign rem = a2 - DIV_W'(est2) * DIV_W'(SCALE_DIV);

  always_ff @(posedge clk) begin
    if (adv.st3) begin
      level <= (rem >= DIV_W'(SCALE_DIV)) ? est2 + CH_W'(1) : est2;
    end
  end

endmodule

### src/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// hsv      in         hsv_valid / hsv_ready  hue[8:0], saturation[6:0], brightness[6:0]
// rgb      out        rgb_valid / rgb_ready  red[7:0], green[7:0], blue[7:0]
//
// seven register stages; rgb_valid rises once a taken beat has moved from the first stage to the seventh
// one beat per cycle sustained while rgb_ready stays high; the chain of per-stage valid bits sets the rate
// rst (synchronous) clears only the valid bits; data registers are not reset
// a stall at rgb_ready holds only the full stages; bubbles still close up

module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             hsv_valid,
  output logic             hsv_ready,
  input  logic [HUE_W-1:0] hue,
  input  logic [PCT_W-1:0] saturation,
  input  logic [PCT_W-1:0] brightness,
  output logic             rgb_valid,
  input  logic             rgb_ready,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue
);

  localparam int NSTG = 7;

  // per-stage valid bits and advance strobes
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || rgb_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= hsv_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign hsv_ready = en[0];
  assign rgb_valid = vld[NSTG-1];

  // stages 1..3: clamp, products, chroma / secondary / offset
  stage_adv_t      front_adv;
  sector_t         sector;
  logic [NUM_W-1:0] chroma;
  logic [NUM_W-1:0] second;
  logic [NUM_W-1:0] offset;

  assign front_adv = '{st1: en[0], st2: en[1], st3: en[2]};

  hsv2rgb_front u_front (
    .clk        (clk),
    .adv        (front_adv),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sector     (sector),
    .chroma     (chroma),
    .second     (second),
    .offset     (offset)
  );

  // stage 4: sector places chroma and secondary, offset added to each
  logic [NUM_W-1:0] r_cmp, g_cmp, b_cmp;
  logic [NUM_W-1:0] r_num, g_num, b_num;

  always_comb begin
    case (sector)
      SEC_RY: begin r_cmp = chroma; g_cmp = second; b_cmp = '0;     end
      SEC_YG: begin r_cmp = second; g_cmp = chroma; b_cmp = '0;     end
      SEC_GC: begin r_cmp = '0;     g_cmp = chroma; b_cmp = second; end
      SEC_CB: begin r_cmp = '0;     g_cmp = second; b_cmp = chroma; end
      SEC_BM: begin r_cmp = second; g_cmp = '0;     b_cmp = chroma; end
      default: begin r_cmp = chroma; g_cmp = '0;    b_cmp = second; end
    endcase
  end

  // sums never pass 600000, so no carry out of NUM_W
  always_ff @(posedge clk) begin
    if (en[3]) begin
      r_num <= r_cmp + offset;
      g_num <= g_cmp + offset;
      b_num <= b_cmp + offset;
    end
  end

  // stages 5..7: floor(num * 255 / 600000) per channel
  stage_adv_t scale_adv;

  assign scale_adv = '{st1: en[4], st2: en[5], st3: en[6]};

  hsv2rgb_scale u_scale_r (.clk(clk), .adv(scale_adv), .num(r_num), .level(red));
  hsv2rgb_scale u_scale_g (.clk(clk), .adv(scale_adv), .num(g_num), .level(green));
  hsv2rgb_scale u_scale_b (.clk(clk), .adv(scale_adv), .num(b_num), .level(blue));

  // an accepted beat lands in the first stage
  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv_ready |=> vld[0])
    else $error("accepted beat missing from first stage");

  // a full stage that cannot advance keeps its beat
  a_mid_hold : assert property (@(posedge clk) disable iff (rst)
    vld[3] && !en[3] |=> vld[3])
    else $error("stalled middle stage dropped its beat");

  // a stalled beat at the output blocks the intake only when the pipe is full
  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    !hsv_ready |-> (vld == {NSTG{1'b1}}) && !rgb_ready)
    else $error("intake stalled with a free stage");

  // reset empties the pipe
  a_reset_empty : assert property (@(posedge clk)
    rst |=> vld == '0)
    else $error("valid bits survive reset");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hsv2rgb_pkg::*;

  // full channel scale and the common denominator of the fixed-point channel sums
  localparam int unsigned CH_SCALE   = 255;
  localparam int unsigned NUM_DENOM  = 600000;
  localparam int          RAND_BEATS = 1100;
  localparam int          QUIET_TAIL = 100;   // last beats of the run go without idling
  localparam int          FLUSH_WAIT = 20;    // seven-stage pipe plus margin
  localparam int          STUCK_MAX  = 1000;  // cycles with no beat on either side

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
    bit               drain_first;  // hold this beat back until the pipe is empty
  } hsv_beat_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             hsv_valid = 1'b0;
  logic             hsv_ready;
  logic [HUE_W-1:0] hue = '0;
  logic [PCT_W-1:0] saturation = '0;
  logic [PCT_W-1:0] brightness = '0;
  logic             rgb_valid;
  logic             rgb_ready = 1'b0;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  hsv_beat_t hsv_backlog[$];   // beats still to be sent
  rgb_beat_t rgb_owed[$];      // predicted colors, oldest first

  bit hsv_taken = 1'b0;        // input beat accepted at the last rising edge
  int send_gap  = 0;
  int stall_gap = 0;
  int send_pct  = 10;
  int stall_pct = 10;
  int mode_cnt  = 0;
  int stuck_cnt = 0;
  int bad_beats = 0;

  hsv_to_rgb_converter_core DUT (
    .clk        (clk),
    .rst        (rst),
    .hsv_valid  (hsv_valid),
    .hsv_ready  (hsv_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // channel value from a numerator in units of 1/600000, truncated toward zero
  function automatic logic [CH_W-1:0] channel_level(int unsigned num);
    longint unsigned scaled;
    scaled = longint'(num) * CH_SCALE / NUM_DENOM;
    return CH_W'(scaled);
  endfunction

  // expected color for one beat, all exact integer arithmetic
  function automatic rgb_beat_t rgb_from_hsv(hsv_beat_t b);
    int unsigned h, s, v, fold, ramp, chroma, second, base;
    int unsigned r, g, bl;
    sector_t     sec;
    rgb_beat_t   px;
    h = b.hue;
    s = b.saturation;
    v = b.brightness;
    // hue at or past a full turn maps to 0
    if (h >= HUE_TURN) h = 0;
    // percentages past 100 saturate
    if (s > PCT_FULL) s = PCT_FULL;
    if (v > PCT_FULL) v = PCT_FULL;
    // ramp rises 0..60 over even sectors and falls over odd ones
    fold = h % (2 * SECTOR_DEG);
    ramp = (fold >= SECTOR_DEG) ? (2 * SECTOR_DEG - fold) : fold;
    chroma = SECTOR_DEG * s * v;
    second = ramp * s * v;
    base   = SECTOR_DEG * v * (PCT_FULL - s);
    sec = sector_t'(h / SECTOR_DEG);
    case (sec)
      SEC_RY:  begin r = chroma; g = second; bl = 0;      end
      SEC_YG:  begin r = second; g = chroma; bl = 0;      end
      SEC_GC:  begin r = 0;      g = chroma; bl = second; end
      SEC_CB:  begin r = 0;      g = second; bl = chroma; end
      SEC_BM:  begin r = second; g = 0;      bl = chroma; end
      default: begin r = chroma; g = 0;      bl = second; end
    endcase
    px.red   = channel_level(r + base);
    px.green = channel_level(g + base);
    px.blue  = channel_level(bl + base);
    return px;
  endfunction

  task automatic report_miscompare(string what, int got, int want);
    $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    bad_beats++;
  endtask

  task automatic queue_hsv(int h, int s, int v, bit drain_first);
    hsv_beat_t b;
    b.hue         = HUE_W'(h);
    b.saturation  = PCT_W'(s);
    b.brightness  = PCT_W'(v);
    b.drain_first = drain_first;
    hsv_backlog.push_back(b);
  endtask

  // sender: moves to the next beat only once the current one is accepted
  always @(negedge clk) begin : hsv_driver
    hsv_beat_t nxt;
    logic      drive_v;
    drive_v = hsv_valid;
    if (!rst && !(hsv_valid && !hsv_taken)) begin
      drive_v = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (hsv_backlog.size() > QUIET_TAIL && $urandom_range(0, 99) < send_pct) begin
        // idle now and draw a random gap length
        send_gap = $urandom_range(0, 11);
      end else if (hsv_backlog.size() != 0 &&
                   !(hsv_backlog[0].drain_first && rgb_owed.size() != 0)) begin
        nxt = hsv_backlog.pop_front();
        hue        <= nxt.hue;
        saturation <= nxt.saturation;
        brightness <= nxt.brightness;
        drive_v = 1'b1;
      end
    end
    hsv_valid <= drive_v;
  end

  // receiver: ready drops in bursts, none starting during the quiet tail
  always @(negedge clk) begin : rgb_sink
    if (stall_gap > 0) begin
      stall_gap--;
      rgb_ready <= 1'b0;
    end else if (hsv_backlog.size() > QUIET_TAIL && $urandom_range(0, 99) < stall_pct) begin
      stall_gap = $urandom_range(0, 11);
      rgb_ready <= 1'b0;
    end else begin
      rgb_ready <= 1'b1;
    end
  end

  // accepted input beats feed the predictor, accepted output beats are checked
  always @(posedge clk) begin : beat_monitor
    hsv_beat_t in_beat;
    rgb_beat_t want;
    bit        moved;
    bit        took;
    moved = 1'b0;
    took  = 1'b0;
    if (!rst) begin
      if (hsv_valid && hsv_ready === 1'b1) begin
        in_beat.hue         = hue;
        in_beat.saturation  = saturation;
        in_beat.brightness  = brightness;
        in_beat.drain_first = 1'b0;
        rgb_owed.push_back(rgb_from_hsv(in_beat));
        took  = 1'b1;
        moved = 1'b1;
      end
      if (rgb_valid === 1'b1 && rgb_ready) begin
        moved = 1'b1;
        if (rgb_owed.size() == 0) begin
          report_miscompare("rgb beat with nothing pending, red", red, 0);
        end else begin
          want = rgb_owed.pop_front();
          if (red !== want.red) report_miscompare("red", red, want.red);
          if (green !== want.green) report_miscompare("green", green, want.green);
          if (blue !== want.blue) report_miscompare("blue", blue, want.blue);
        end
      end
    end
    hsv_taken <= took;
    stuck_cnt <= moved ? 0 : stuck_cnt + 1;
    // idle intensity is redrawn periodically from mode_cnt, zero included for clean stretches
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 128 == 127) begin
      case ($urandom_range(0, 3))
        0: send_pct <= 0;
        1: send_pct <= 5;
        2: send_pct <= 20;
        default: send_pct <= 40;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 5;
        2: stall_pct <= 20;
        default: stall_pct <= 40;
      endcase
    end
  end

  // watchdog on cycles without any beat
  initial begin
    while (stuck_cnt < STUCK_MAX) @(posedge clk);
    $display("hsv_to_rgb_converter_core test failed");
    $finish;
  end

  initial begin : stimulus
    int pick, k, h, s, v;
    // primary and secondary colors at full saturation and value, plus hue 359
    queue_hsv(0, 100, 100, 1'b0);
    queue_hsv(60, 100, 100, 1'b0);
    queue_hsv(120, 100, 100, 1'b0);
    queue_hsv(180, 100, 100, 1'b0);
    queue_hsv(240, 100, 100, 1'b0);
    queue_hsv(300, 100, 100, 1'b0);
    queue_hsv(359, 100, 100, 1'b0);
    // full turn and larger hues map to zero
    queue_hsv(360, 100, 100, 1'b0);
    queue_hsv(361, 100, 100, 1'b0);
    queue_hsv(511, 100, 100, 1'b0);
    // mid-sector ramps
    queue_hsv(30, 100, 100, 1'b0);
    queue_hsv(90, 50, 50, 1'b0);
    queue_hsv(61, 99, 99, 1'b0);
    queue_hsv(119, 1, 1, 1'b0);
    queue_hsv(256, 64, 64, 1'b0);
    // black and white
    queue_hsv(0, 0, 0, 1'b0);
    queue_hsv(0, 0, 100, 1'b0);
    queue_hsv(200, 0, 100, 1'b0);
    queue_hsv(45, 100, 0, 1'b0);
    // saturation and value past 100
    queue_hsv(150, 127, 127, 1'b0);
    queue_hsv(270, 101, 100, 1'b0);
    queue_hsv(330, 100, 101, 1'b0);
    queue_hsv(511, 127, 127, 1'b0);
    queue_hsv(0, 127, 0, 1'b0);

    for (int i = 0; i < RAND_BEATS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        h = $urandom_range(0, 360);
        s = $urandom_range(0, 100);
        v = $urandom_range(0, 100);
      end else if (pick < 88) begin
        // around sector edges, with extreme percentages now and then
        k = $urandom_range(0, 6);
        h = SECTOR_DEG * k + $urandom_range(0, 2) - 1;
        if (h < 0) h = 0;
        s = $urandom_range(0, 1) ? $urandom_range(0, 100) : 100 * $urandom_range(0, 1);
        v = $urandom_range(0, 1) ? $urandom_range(0, 100) : 100 * $urandom_range(0, 1);
      end else begin
        // raw field values, out of range included
        h = $urandom_range(0, 511);
        s = $urandom_range(0, 127);
        v = $urandom_range(0, 127);
      end
      // drain the pipe before the first random beat and a few more times
      queue_hsv(h, s, v, (i % 300) == 0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait until every beat is sent and every color has come back
    while (hsv_backlog.size() != 0 || hsv_valid || rgb_owed.size() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
    @(negedge clk);
    if (rgb_owed.size() != 0) report_miscompare("colors never returned", 0, rgb_owed.size());
    if (bad_beats == 0) begin
      $display("hsv_to_rgb_converter_core test passed");
    end else begin
      $display("hsv_to_rgb_converter_core test failed");
    end
    $finish;
  end

endmodule

### hsv_to_rgb_converter_core.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_front.sv
src/hsv2rgb_scale.sv
src/hsv_to_rgb_converter_core.sv
tb/sv/tb_top.sv
